// ===== rtl/quadratic_probe_hash_set_core_macros.svh =====
// quadratic_probe_hash_set_core_macros.svh: assertion macros for the hash table checks
// expects clk and rst to be visible where a macro is used
`ifndef QUADRATIC_PROBE_HASH_SET_CORE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_SET_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define QPHS_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qphs: same-cycle check failed");

// next-cycle implication, held off during reset
`define QPHS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qphs: next-cycle check failed");

`endif

// ===== rtl/qphs_pkg.sv =====
// qphs_pkg: shared types and fixed codes of the quadratic probe hash table
// no dependencies; used by qphs_ctrl, qphs_dp and the top level
package qphs_pkg;

  // key bits folded into the home slot residue per hash cycle
  localparam int DIGIT_W = 4;
  // bits of slot state stored per entry
  localparam int SLOT_W  = 2;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_LIMIT = 2'd2
  } rsp_status_t;

  typedef enum logic [3:0] {
    S_SWEEP_RST,
    S_IDLE,
    S_HASH,
    S_SWEEP_CLR,
    S_READ,
    S_CHECK,
    S_WRITE,
    S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    RES_MISS,
    RES_HIT,
    RES_PLACED,
    RES_FULL,
    RES_LIMIT,
    RES_CLEAR
  } outcome_t;

  // controller to datapath
  typedef struct packed {
    logic     take;
    logic     hash_step;
    logic     probe_init;
    logic     mem_read;
    logic     probe_next;
    logic     sweep_init;
    logic     sweep_step;
    logic     mem_write;
    logic     wr_clear;
    logic     wr_tomb;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     res_load;
    outcome_t outcome;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  hash_last;
    logic  slot_empty;
    logic  slot_hit;
    logic  probe_last;
    logic  sweep_last;
    logic  table_full;
    logic  rsp_free;
  } dp_status_t;

endpackage

// ===== rtl/qphs_ram.sv =====
// qphs_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module qphs_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 1033
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/qphs_ctrl.sv =====
// qphs_ctrl: operation sequencer of the hash table (sweep, hash, probe, write, result)
// depends on qphs_pkg
module qphs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  qphs_pkg::dp_status_t st,
  output qphs_pkg::dp_cmd_t    cmd
);

  qphs_pkg::state_t   state, state_next;
  qphs_pkg::outcome_t outcome, outcome_next;

  // state and outcome registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= qphs_pkg::S_SWEEP_RST;
      outcome <= qphs_pkg::RES_MISS;
    end else begin
      state   <= state_next;
      outcome <= outcome_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next   = state;
    outcome_next = outcome;
    cmd          = '0;
    req_stall    = 1'b1;
    case (state)
      qphs_pkg::S_SWEEP_RST: begin
        cmd.mem_write  = 1'b1;
        cmd.wr_clear   = 1'b1;
        cmd.sweep_step = 1'b1;
        if (st.sweep_last) begin
          state_next = qphs_pkg::S_IDLE;
        end
      end
      qphs_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = qphs_pkg::S_HASH;
        end
      end
      qphs_pkg::S_HASH: begin
        if (st.mode == qphs_pkg::MODE_CLEAR) begin
          cmd.sweep_init = 1'b1;
          state_next     = qphs_pkg::S_SWEEP_CLR;
        end else begin
          cmd.hash_step = 1'b1;
          if (st.hash_last) begin
            cmd.probe_init = 1'b1;
            state_next     = qphs_pkg::S_READ;
          end
        end
      end
      qphs_pkg::S_SWEEP_CLR: begin
        cmd.mem_write  = 1'b1;
        cmd.wr_clear   = 1'b1;
        cmd.sweep_step = 1'b1;
        if (st.sweep_last) begin
          outcome_next = qphs_pkg::RES_CLEAR;
          state_next   = qphs_pkg::S_RESULT;
        end
      end
      qphs_pkg::S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = qphs_pkg::S_CHECK;
      end
      qphs_pkg::S_CHECK: begin
        if (st.slot_hit) begin
          outcome_next = qphs_pkg::RES_HIT;
          if (st.mode == qphs_pkg::MODE_INSERT || st.mode == qphs_pkg::MODE_REMOVE) begin
            state_next = qphs_pkg::S_WRITE;
          end else begin
            state_next = qphs_pkg::S_RESULT;
          end
        end else if (st.slot_empty) begin
          if (st.mode == qphs_pkg::MODE_INSERT) begin
            if (st.table_full) begin
              outcome_next = qphs_pkg::RES_FULL;
              state_next   = qphs_pkg::S_RESULT;
            end else begin
              outcome_next = qphs_pkg::RES_PLACED;
              state_next   = qphs_pkg::S_WRITE;
            end
          end else begin
            outcome_next = qphs_pkg::RES_MISS;
            state_next   = qphs_pkg::S_RESULT;
          end
        end else if (st.probe_last) begin
          outcome_next = qphs_pkg::RES_LIMIT;
          state_next   = qphs_pkg::S_RESULT;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = qphs_pkg::S_READ;
        end
      end
      qphs_pkg::S_WRITE: begin
        cmd.mem_write = 1'b1;
        if (st.mode == qphs_pkg::MODE_REMOVE) begin
          cmd.wr_tomb = 1'b1;
          cmd.cnt_dec = 1'b1;
        end else if (outcome == qphs_pkg::RES_PLACED) begin
          cmd.cnt_inc = 1'b1;
        end
        state_next = qphs_pkg::S_RESULT;
      end
      qphs_pkg::S_RESULT: begin
        if (st.rsp_free) begin
          cmd.res_load = 1'b1;
          state_next   = qphs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = qphs_pkg::S_SWEEP_RST;
      end
    endcase
    cmd.outcome = outcome;
  end

endmodule

// ===== rtl/qphs_dp.sv =====
// qphs_dp: request registers, home-slot residue, probe index, slot RAM, count and result beat
// depends on qphs_pkg and qphs_ram
module qphs_dp #(
  parameter int CAPACITY    = 1033,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [1:0]                           mode,
  input  logic [KEY_WIDTH-1:0]                 key,
  input  logic [VALUE_WIDTH-1:0]               value_in,
  input  qphs_pkg::dp_cmd_t                    cmd,
  output qphs_pkg::dp_status_t                 st,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output logic                                 found,
  output logic [$clog2(CAPACITY)-1:0]          slot_index,
  output logic [VALUE_WIDTH-1:0]               value_out,
  output logic [$clog2(CAPACITY/2+1)-1:0]      live_count,
  output logic [1:0]                           status
);

  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY/2 + 1);
  localparam int KEY_DIGITS = (KEY_WIDTH + qphs_pkg::DIGIT_W - 1) / qphs_pkg::DIGIT_W;
  localparam int PAD_W      = KEY_DIGITS * qphs_pkg::DIGIT_W;
  localparam int HCNT_W     = $clog2(KEY_DIGITS);
  localparam int WORD_W     = qphs_pkg::SLOT_W + KEY_WIDTH + VALUE_WIDTH;
  localparam logic [IDX_W:0]   CAP_X    = (IDX_W+1)'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] HALF_CAP = CNT_W'(CAPACITY / 2);

  qphs_pkg::mode_t  req_mode;
  logic [KEY_WIDTH-1:0]   req_key;
  logic [VALUE_WIDTH-1:0] req_value;
  logic [PAD_W-1:0]       hkey;
  logic [HCNT_W-1:0]      hcnt;
  logic [IDX_W-1:0]       resid, resid_next;
  logic [IDX_W:0]         fold;
  logic [IDX_W-1:0]       idx, delta, pcnt;
  logic [IDX_W:0]         idx_sum, delta_sum;
  logic [IDX_W-1:0]       idx_adv, delta_adv;
  logic [CNT_W-1:0]       live;
  logic [WORD_W-1:0]      rd_word, wr_word;
  logic [qphs_pkg::SLOT_W-1:0] rd_slot;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic                   rsp_free;

  // request capture and residue of key mod capacity, one digit per cycle
  always_comb begin
    fold = {1'b0, resid};
    for (int b = 0; b < qphs_pkg::DIGIT_W; b++) begin
      fold = {fold[IDX_W-1:0], hkey[PAD_W-1-b]};
      if (fold >= CAP_X) begin
        fold = fold - CAP_X;
      end
    end
    resid_next = fold[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_mode  <= qphs_pkg::mode_t'(mode);
      req_key   <= key;
      req_value <= value_in;
      hkey      <= PAD_W'(key);
      hcnt      <= '0;
      resid     <= '0;
    end else if (cmd.hash_step) begin
      hkey  <= hkey << qphs_pkg::DIGIT_W;
      hcnt  <= hcnt + HCNT_W'(1);
      resid <= resid_next;
    end
  end

  // quadratic step: index and odd increment both kept reduced mod capacity
  always_comb begin
    idx_sum   = {1'b0, idx} + {1'b0, delta};
    idx_adv   = (idx_sum >= CAP_X) ? IDX_W'(idx_sum - CAP_X) : idx_sum[IDX_W-1:0];
    delta_sum = {1'b0, delta} + (IDX_W+1)'(2);
    delta_adv = (delta_sum >= CAP_X) ? IDX_W'(delta_sum - CAP_X) : delta_sum[IDX_W-1:0];
  end

  // probe index doubles as the sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.sweep_init) begin
      idx <= '0;
    end else if (cmd.probe_init) begin
      idx <= resid_next;
    end else if (cmd.sweep_step) begin
      idx <= idx + IDX_W'(1);
    end else if (cmd.probe_next) begin
      idx <= idx_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      delta <= IDX_W'(1);
      pcnt  <= '0;
    end else if (cmd.probe_next) begin
      delta <= delta_adv;
      pcnt  <= pcnt + IDX_W'(1);
    end
  end

  // slot store: state, key and value in one word
  assign rd_slot  = rd_word[WORD_W-1 -: qphs_pkg::SLOT_W];
  assign rd_key   = rd_word[VALUE_WIDTH +: KEY_WIDTH];
  assign rd_value = rd_word[VALUE_WIDTH-1:0];

  always_comb begin
    if (cmd.wr_clear) begin
      wr_word = {qphs_pkg::SLOT_EMPTY, {KEY_WIDTH{1'b0}}, {VALUE_WIDTH{1'b0}}};
    end else if (cmd.wr_tomb) begin
      wr_word = {qphs_pkg::SLOT_TOMB, req_key, rd_value};
    end else begin
      wr_word = {qphs_pkg::SLOT_LIVE, req_key, req_value};
    end
  end

  qphs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.mem_write),
    .waddr (idx),
    .wdata (wr_word),
    .re    (cmd.mem_read),
    .raddr (idx),
    .rdata (rd_word)
  );

  // live key count
  always_ff @(posedge clk) begin
    if (rst || cmd.sweep_init) begin
      live <= '0;
    end else if (cmd.cnt_inc) begin
      live <= live + CNT_W'(1);
    end else if (cmd.cnt_dec && live != '0) begin
      live <= live - CNT_W'(1);
    end
  end

  // result beat register
  assign rsp_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      live_count <= live;
      found      <= 1'b0;
      slot_index <= '0;
      value_out  <= '0;
      status     <= qphs_pkg::STAT_OK;
      case (cmd.outcome)
        qphs_pkg::RES_HIT: begin
          found      <= 1'b1;
          slot_index <= idx;
          value_out  <= rd_value;
        end
        qphs_pkg::RES_PLACED: begin
          slot_index <= idx;
        end
        qphs_pkg::RES_FULL: begin
          status <= qphs_pkg::STAT_FULL;
        end
        qphs_pkg::RES_LIMIT: begin
          status <= qphs_pkg::STAT_LIMIT;
        end
        default: begin
          status <= qphs_pkg::STAT_OK;
        end
      endcase
    end
  end

  // status to the sequencer
  always_comb begin
    st            = '0;
    st.mode       = req_mode;
    st.hash_last  = (hcnt == HCNT_W'(KEY_DIGITS - 1));
    st.slot_empty = (rd_slot == qphs_pkg::SLOT_EMPTY);
    st.slot_hit   = (rd_slot == qphs_pkg::SLOT_LIVE) && (rd_key == req_key);
    st.probe_last = (pcnt == LAST_IDX);
    st.sweep_last = (idx == LAST_IDX);
    st.table_full = (live >= HALF_CAP);
    st.rsp_free   = rsp_free;
  end

endmodule

// ===== rtl/quadratic_probe_hash_set_core.sv =====
// Open-addressing key/value table of CAPACITY slots (a prime) with quadratic probing: the home
// slot is key mod CAPACITY and the probe moves on by 1, 3, 5, ... modulo CAPACITY, passing over
// tombstones and stopping at an empty slot or a live matching key. Each request beat performs
// a lookup, insert/update, remove (leaves a tombstone) or clear and gives one result beat;
// a new key is refused with full status once CAPACITY/2 keys are live, and a probe that finds
// neither match nor empty slot in CAPACITY slots ends with probe-limit status. One request is
// in work at a time; the result sits in an output register, so the next request is taken
// while it waits. The home residue is folded 4 key bits per cycle, and each probe is a read
// of the slot RAM's single registered read port followed by the compare; an insert or remove
// that hits or places a key adds a write of the slot. A clear runs a clearing pass over all
// CAPACITY slots (1033 by default); the same pass runs after reset with req_stall high.
// Built from qphs_ctrl (sequencer) and qphs_dp (datapath and slot RAM); types in qphs_pkg.
module quadratic_probe_hash_set_core #(
  parameter int CAPACITY    = 1033,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [1:0]                      mode,
  input  logic [KEY_WIDTH-1:0]            key,
  input  logic [VALUE_WIDTH-1:0]          value_in,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic                            found,
  output logic [$clog2(CAPACITY)-1:0]     slot_index,
  output logic [VALUE_WIDTH-1:0]          value_out,
  output logic [$clog2(CAPACITY/2+1)-1:0] live_count,
  output logic [1:0]                      status
);

  qphs_pkg::dp_cmd_t    cmd;
  qphs_pkg::dp_status_t st;

  // sequencer
  qphs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath with slot RAM
  qphs_dp #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .key        (key),
    .value_in   (value_in),
    .cmd        (cmd),
    .st         (st),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .found      (found),
    .slot_index (slot_index),
    .value_out  (value_out),
    .live_count (live_count),
    .status     (status)
  );

endmodule

// ===== rtl/qphs_checker.sv =====
// qphs_checker: port-level checks of the hash table core, bound to the top level
// depends on quadratic_probe_hash_set_core_macros.svh
`include "quadratic_probe_hash_set_core_macros.svh"

module qphs_checker #(
  parameter int CAPACITY    = 1033,
  parameter int VALUE_WIDTH = 32
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_stall,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input logic                            found,
  input logic [$clog2(CAPACITY)-1:0]     slot_index,
  input logic [VALUE_WIDTH-1:0]          value_out,
  input logic [$clog2(CAPACITY/2+1)-1:0] live_count,
  input logic [1:0]                      status
);

  // an accepted request keeps the block busy for at least the next cycle
  `QPHS_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall)

  // the live count never passes half the capacity
  `QPHS_ASSERT_SAME(a_count_bound, rsp_valid, live_count <= ($clog2(CAPACITY/2+1))'(CAPACITY/2))

  // a refused or cut-off operation reports nothing else
  `QPHS_ASSERT_SAME(a_error_quiet, rsp_valid && status != 2'd0, !found && slot_index == '0 && value_out == '0)

  // value only comes back with a hit
  `QPHS_ASSERT_SAME(a_miss_no_value, rsp_valid && !found, value_out == '0)

  // a stalled result beat holds
  `QPHS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(value_out) && $stable(live_count))

endmodule

bind quadratic_probe_hash_set_core qphs_checker #(
  .CAPACITY    (CAPACITY),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_qphs_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_stall  (req_stall),
  .rsp_valid  (rsp_valid),
  .rsp_stall  (rsp_stall),
  .found      (found),
  .slot_index (slot_index),
  .value_out  (value_out),
  .live_count (live_count),
  .status     (status)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// testbench for quadratic_probe_hash_set_core: directed table then random churn and a fill run
// depends on qphs_pkg and the core; results are checked against a table model kept here
module testbench;
  import qphs_pkg::*;

  localparam int CAP  = 1033;
  localparam int HALF = CAP / 2;

  typedef enum logic [1:0] {PR_HIT, PR_EMPTY, PR_LIMIT} probe_end_t;

  typedef struct packed {
    logic        found;
    logic [10:0] slot;
    logic [31:0] value;
    logic [9:0]  count;
    rsp_status_t status;
  } table_rsp_t;

  typedef struct {
    mode_t       op;
    logic [31:0] k;
    logic [31:0] v;
    bit          known;
    table_rsp_t  want;
  } table_req_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  mode      = MODE_LOOKUP;
  logic [31:0] key       = '0;
  logic [31:0] value_in  = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic        found;
  logic [10:0] slot_index;
  logic [31:0] value_out;
  logic [9:0]  live_count;
  logic [1:0]  status;

  quadratic_probe_hash_set_core u_top (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .mode       (mode),
    .key        (key),
    .value_in   (value_in),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .found      (found),
    .slot_index (slot_index),
    .value_out  (value_out),
    .live_count (live_count),
    .status     (status)
  );

  // table model state
  slot_t       slot_st  [CAP];
  logic [31:0] slot_keys[CAP];
  logic [31:0] slot_vals[CAP];
  int unsigned live_n;

  table_req_t  plan[$];
  table_req_t  req_cur;
  table_rsp_t  due_rsp[$];
  int unsigned mismatches = 0;

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #8_000_000;
    $display("quadratic_probe_hash_set_core test failed");
    $finish;
  end

  function automatic void wipe_table();
    foreach (slot_st[i]) slot_st[i] = SLOT_EMPTY;
    live_n = 0;
  endfunction

  // quadratic walk from the home slot: stops on empty or matching live slot
  function automatic probe_end_t probe_for(input logic [31:0] k, output int unsigned at);
    int unsigned idx;
    int unsigned step;
    idx  = k % CAP;
    step = 1;
    at   = 0;
    for (int n = 0; n < CAP; n++) begin
      if (slot_st[idx] == SLOT_EMPTY) begin
        at = idx;
        return PR_EMPTY;
      end
      if (slot_st[idx] == SLOT_LIVE && slot_keys[idx] == k) begin
        at = idx;
        return PR_HIT;
      end
      idx  = (idx + step) % CAP;
      step += 2;
    end
    return PR_LIMIT;
  endfunction

  // one table operation: updates the model and gives the result beat
  function automatic table_rsp_t apply_table_op(input mode_t op, input logic [31:0] k,
                                                input logic [31:0] v);
    table_rsp_t o;
    probe_end_t pe;
    int unsigned at;
    o = '0;
    o.status = STAT_OK;
    if (op == MODE_CLEAR) begin
      wipe_table();
    end else begin
      pe = probe_for(k, at);
      case (pe)
        PR_LIMIT: o.status = STAT_LIMIT;
        PR_HIT: begin
          o.found = 1'b1;
          o.slot  = at[10:0];
          o.value = slot_vals[at];
          if (op == MODE_INSERT) begin
            slot_vals[at] = v;
          end else if (op == MODE_REMOVE) begin
            slot_st[at] = SLOT_TOMB;
            if (live_n > 0) live_n--;
          end
        end
        default: begin
          if (op == MODE_INSERT) begin
            if (live_n >= HALF) begin
              o.status = STAT_FULL;
            end else begin
              slot_st[at]   = SLOT_LIVE;
              slot_keys[at] = k;
              slot_vals[at] = v;
              live_n++;
              o.slot = at[10:0];
            end
          end
        end
      endcase
    end
    o.count = live_n[9:0];
    return o;
  endfunction

  function automatic table_req_t op_row(input mode_t op, input logic [31:0] k,
                                        input logic [31:0] v);
    table_req_t r;
    r.op    = op;
    r.k     = k;
    r.v     = v;
    r.known = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic table_req_t known_row(input mode_t op, input logic [31:0] k,
                                           input logic [31:0] v, input logic f,
                                           input logic [10:0] s, input logic [31:0] val,
                                           input logic [9:0] c, input rsp_status_t st);
    table_req_t r;
    r = op_row(op, k, v);
    r.known = 1'b1;
    r.want  = '{f, s, val, c, st};
    return r;
  endfunction

  // random operations on a few crowded home slots plus scattered keys
  task automatic add_churn(input int n_ops);
    int unsigned home[4];
    int unsigned pick;
    logic [31:0] k;
    mode_t       op;
    foreach (home[i]) home[i] = $urandom_range(0, CAP - 1);
    // one home near the top so the walk wraps
    home[3] = CAP - 1 - $urandom_range(0, 3);
    repeat (n_ops) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) op = MODE_CLEAR;
      else if (pick < 40) op = MODE_INSERT;
      else if (pick < 70) op = MODE_LOOKUP;
      else op = MODE_REMOVE;
      if ($urandom_range(0, 4) == 0) k = $urandom;
      else k = home[$urandom_range(0, 3)] + CAP * $urandom_range(0, 7);
      plan.push_back(op_row(op, k, $urandom));
    end
  endtask

  // fill every slot on the walk of one home: one tombstone and HALF live keys,
  // so that home runs out of probes and any new key is refused
  task automatic add_fill();
    bit          is_sq[CAP];
    int unsigned tgt[$];
    logic [31:0] keys[$];
    int unsigned h;
    int unsigned j;
    int unsigned t;
    logic [31:0] k;
    h = $urandom_range(0, CAP - 1);
    for (int n = 0; n <= HALF; n++) is_sq[(n * n) % CAP] = 1'b1;
    for (int r = 0; r < CAP; r++) if (is_sq[r]) tgt.push_back((h + r) % CAP);
    for (int i = tgt.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = tgt[i];
      tgt[i] = tgt[j];
      tgt[j] = t;
    end
    foreach (tgt[i]) begin
      if (i == HALF) begin
        // make room for the last key, leaving a tombstone on the walk
        plan.push_back(op_row(MODE_REMOVE, keys[$urandom_range(0, HALF - 1)], $urandom));
      end else if (i > 0 && $urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 2))
          0:       plan.push_back(op_row(MODE_LOOKUP, keys[$urandom_range(0, i - 1)], $urandom));
          1:       plan.push_back(op_row(MODE_INSERT, keys[$urandom_range(0, i - 1)], $urandom));
          default: plan.push_back(op_row(MODE_LOOKUP, $urandom, $urandom));
        endcase
      end
      k = tgt[i] + CAP * $urandom_range(0, (32'hFFFF_FFFF - tgt[i]) / CAP);
      keys.push_back(k);
      plan.push_back(op_row(MODE_INSERT, k, $urandom));
    end
    // new keys on the blocked home run out of probes
    repeat (6) begin
      k = h + CAP * $urandom_range(0, (32'hFFFF_FFFF - h) / CAP);
      plan.push_back(op_row(mode_t'($urandom_range(0, 2)), k, $urandom));
    end
    // table full
    repeat (3) plan.push_back(op_row(MODE_INSERT, $urandom, $urandom));
    plan.push_back(op_row(MODE_LOOKUP, keys[HALF], $urandom));
    plan.push_back(op_row(MODE_REMOVE, keys[HALF], $urandom));
    plan.push_back(op_row(MODE_INSERT, $urandom, 32'hFFFF_FFFF));
    plan.push_back(op_row(MODE_INSERT, $urandom, 32'h0));
    plan.push_back(op_row(MODE_CLEAR, $urandom, $urandom));
  endtask

  task automatic flag(input string what, input logic [63:0] exp_v, input logic [63:0] act_v);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: %s expected %0h got %0h", $time, what, exp_v, act_v);
  endtask

  // receiver stall pattern, redrawn whenever the low seven bits of the tick counter are zero
  logic [15:0] stall_pat  = '0;
  logic [7:0]  stall_tick = '0;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[6:0] == 7'd0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat <= '0;
        1:       stall_pat <= $urandom;
        2:       stall_pat <= $urandom | $urandom;
        default: stall_pat <= $urandom & $urandom;
      endcase
    end
    rsp_stall <= stall_pat[stall_tick[3:0]];
  end

  // result beats against expectations, request beats into the model
  always @(posedge clk) begin
    table_rsp_t want;
    table_rsp_t pred;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (due_rsp.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with no request outstanding", $time);
        end else begin
          want = due_rsp.pop_front();
          if (found !== want.found)      flag("found", want.found, found);
          if (slot_index !== want.slot)  flag("slot_index", want.slot, slot_index);
          if (value_out !== want.value)  flag("value_out", want.value, value_out);
          if (live_count !== want.count) flag("live_count", want.count, live_count);
          if (status !== want.status)    flag("status", want.status, status);
        end
      end
      if (req_valid && !req_stall) begin
        pred = apply_table_op(mode_t'(mode), key, value_in);
        due_rsp.push_back(req_cur.known ? req_cur.want : pred);
      end
    end
  end

  // stimulus: directed table, random churn, fill to the limit, more churn
  initial begin
    int unsigned burst;
    int unsigned gap;
    int unsigned drain;
    wipe_table();

    plan.push_back(known_row(MODE_LOOKUP, 32'h0, 32'h0, 1'b0, 11'd0, 32'h0, 10'd0, STAT_OK));
    plan.push_back(known_row(MODE_INSERT, 32'h0, 32'hFFFF_FFFF,
                             1'b0, 11'd0, 32'h0, 10'd1, STAT_OK));
    // all-ones key lives at slot 182
    plan.push_back(known_row(MODE_INSERT, 32'hFFFF_FFFF, 32'h0,
                             1'b0, 11'd182, 32'h0, 10'd2, STAT_OK));
    plan.push_back(known_row(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0,
                             1'b1, 11'd182, 32'h0, 10'd2, STAT_OK));
    // update returns the old value
    plan.push_back(known_row(MODE_INSERT, 32'h0, 32'h1234,
                             1'b1, 11'd0, 32'hFFFF_FFFF, 10'd2, STAT_OK));
    plan.push_back(known_row(MODE_LOOKUP, 32'h0, 32'h0, 1'b1, 11'd0, 32'h1234, 10'd2, STAT_OK));
    // three keys sharing home 5, then a tombstone in their chain
    plan.push_back(op_row(MODE_INSERT, 32'd5, 32'hA5A5_5A5A));
    plan.push_back(op_row(MODE_INSERT, 32'd1038, 32'h1));
    plan.push_back(op_row(MODE_INSERT, 32'd2071, 32'h2));
    plan.push_back(op_row(MODE_LOOKUP, 32'd2071, 32'h0));
    plan.push_back(op_row(MODE_REMOVE, 32'd5, 32'h0));
    plan.push_back(op_row(MODE_LOOKUP, 32'd1038, 32'h0));
    plan.push_back(op_row(MODE_INSERT, 32'd5, 32'h3));
    plan.push_back(op_row(MODE_REMOVE, 32'd3104, 32'h0));
    plan.push_back(op_row(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0));
    plan.push_back(op_row(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0));
    plan.push_back(known_row(MODE_CLEAR, 32'h0, 32'h0, 1'b0, 11'd0, 32'h0, 10'd0, STAT_OK));
    plan.push_back(known_row(MODE_LOOKUP, 32'd1038, 32'h0, 1'b0, 11'd0, 32'h0, 10'd0, STAT_OK));
    plan.push_back(known_row(MODE_INSERT, 32'd1033, 32'hFFFF_FFFF,
                             1'b0, 11'd0, 32'h0, 10'd1, STAT_OK));
    // remove miss past a live slot of another key
    plan.push_back(known_row(MODE_REMOVE, 32'h0, 32'h0, 1'b0, 11'd0, 32'h0, 10'd1, STAT_OK));
    plan.push_back(known_row(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             1'b0, 11'd0, 32'h0, 10'd0, STAT_OK));

    add_churn(50);
    add_fill();
    add_churn(30);

    @(posedge clk);
    while (rst) @(posedge clk);

    // request beats in bursts with random gaps
    burst = 0;
    foreach (plan[i]) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap != 0) begin
          req_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
      end
      burst--;
      req_valid <= 1'b1;
      mode      <= plan[i].op;
      key       <= plan[i].k;
      value_in  <= plan[i].v;
      req_cur   <= plan[i];
      do @(posedge clk); while (req_stall);
    end
    req_valid <= 1'b0;

    // drain outstanding results
    drain = 0;
    @(negedge clk);
    while (due_rsp.size() != 0 && drain < 40000) begin
      @(negedge clk);
      drain++;
    end
    repeat (40) @(negedge clk);
    if (due_rsp.size() != 0)
      $display("%0t: %0d results never arrived", $time, due_rsp.size());
    if (mismatches == 0 && due_rsp.size() == 0) begin
      $display("quadratic_probe_hash_set_core test passed");
    end else begin
      $display("quadratic_probe_hash_set_core test failed");
    end
    $finish;
  end

endmodule
